// ===== design/pddm_pkg.sv =====
// ----------------------------------------------------------------------------
// pddm_pkg
// Shared widths, angle constants, arctangent table, mode and register codes
// and cordic control struct for the polar differential drive mixer.
// ----------------------------------------------------------------------------
package pddm_pkg;

    // cordic vector width (24 fraction bits) and angle width (28 fraction bits)
    localparam int XY_W       = 32;
    localparam int ANG_W      = 34;
    localparam int ATAN_COUNT = 24;
    localparam int ATAN_IDX_W = 5;
    localparam int ATAN_W     = 28;

    localparam logic signed [ANG_W-1:0] ANG_PI         = 34'sd843314857;
    localparam logic signed [ANG_W-1:0] ANG_TWO_PI     = 34'sd1686629713;
    localparam logic signed [ANG_W-1:0] ANG_HALF_PI    = 34'sd421657428;
    localparam logic signed [ANG_W-1:0] ANG_QUARTER_PI = 34'sd210828714;

    // 1/K scaled by 2^30
    localparam logic signed [31:0] INV_K = 32'sd652032874;

    typedef enum logic [1:0] {
        MODE_STEERING = 2'd0,
        MODE_THROTTLE = 2'd1,
        MODE_BOTH     = 2'd2,
        MODE_HOLD     = 2'd3
    } drive_mode_t;

    typedef enum logic [1:0] {
        REG_STEERING_GAIN = 2'd0,
        REG_THROTTLE_GAIN = 2'd1,
        REG_ANGLE_OFFSET  = 2'd2
    } mixer_reg_t;

    typedef struct packed {
        logic load;
        logic step;
        logic vec;
    } cordic_ctl_t;

    function automatic logic [ATAN_W-1:0] atan_lut(input logic [ATAN_IDX_W-1:0] idx);
        logic [ATAN_W-1:0] val;
        case (idx)
            5'd0:    val = 28'd210828714;
            5'd1:    val = 28'd124459457;
            5'd2:    val = 28'd65760959;
            5'd3:    val = 28'd33381290;
            5'd4:    val = 28'd16755422;
            5'd5:    val = 28'd8385879;
            5'd6:    val = 28'd4193963;
            5'd7:    val = 28'd2097109;
            5'd8:    val = 28'd1048571;
            5'd9:    val = 28'd524287;
            5'd10:   val = 28'd262144;
            5'd11:   val = 28'd131072;
            5'd12:   val = 28'd65536;
            5'd13:   val = 28'd32768;
            5'd14:   val = 28'd16384;
            5'd15:   val = 28'd8192;
            5'd16:   val = 28'd4096;
            5'd17:   val = 28'd2048;
            5'd18:   val = 28'd1024;
            5'd19:   val = 28'd512;
            5'd20:   val = 28'd256;
            5'd21:   val = 28'd128;
            5'd22:   val = 28'd64;
            5'd23:   val = 28'd32;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

// ===== design/pddm_cordic.sv =====
// ----------------------------------------------------------------------------
// pddm_cordic
// Iterative shift-add cordic, one micro-rotation per step, vectoring or
// rotation mode chosen by the sequencer.
// ----------------------------------------------------------------------------
module pddm_cordic import pddm_pkg::*; #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  cordic_ctl_t             ctl,
    input  logic signed [XY_W-1:0]  x_in,
    input  logic signed [XY_W-1:0]  y_in,
    input  logic signed [ANG_W-1:0] z_in,
    output logic signed [XY_W-1:0]  x_out,
    output logic signed [ANG_W-1:0] z_out,
    output logic                    done
);

    localparam int IT_W = $clog2(CORDIC_STEPS + 1);

    logic signed [XY_W-1:0]  x_reg, y_reg;
    logic signed [ANG_W-1:0] z_reg;
    logic [IT_W-1:0]         iter_reg;

    logic signed [XY_W-1:0]  dx, dy, x_next, y_next;
    logic signed [ANG_W-1:0] atan_val, z_next;
    logic                    sub_x;

    always_comb begin
        dx       = y_reg >>> iter_reg;
        dy       = x_reg >>> iter_reg;
        atan_val = $signed({{(ANG_W-ATAN_W){1'b0}}, atan_lut(ATAN_IDX_W'(iter_reg))});
        // vectoring drives y toward zero, rotation drives z toward zero
        sub_x    = ctl.vec ? y_reg[XY_W-1] : ~z_reg[ANG_W-1];
        x_next   = sub_x ? x_reg - dx : x_reg + dx;
        y_next   = sub_x ? y_reg + dy : y_reg - dy;
        z_next   = sub_x ? z_reg - atan_val : z_reg + atan_val;
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            x_reg <= x_in;
            y_reg <= y_in;
            z_reg <= z_in;
        end else if (ctl.step) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iter_reg <= '0;
        end else if (ctl.load) begin
            iter_reg <= '0;
        end else if (ctl.step) begin
            iter_reg <= iter_reg + 1'b1;
        end
    end

    assign x_out = x_reg;
    assign z_out = z_reg;
    assign done  = (iter_reg == IT_W'(CORDIC_STEPS));

endmodule

// ===== design/polar_differential_drive_mixer.sv =====
// ----------------------------------------------------------------------------
// polar_differential_drive_mixer
// Keeps scaled throttle and steering levels, converts the pair to polar form,
// adds an angle offset and produces forward/reverse duties for both wheels.
// ----------------------------------------------------------------------------
// channel   | dir | handshake                  | content
// s_*       | in  | s_tvalid / s_tready        | steering, throttle word, mode in tuser
// m_*       | out | m_tvalid / m_tready        | four wheel duties
// apb       | in  | psel, penable, pready      | gains and angle offset
//
// a word goes from accept to result through three passes of the shared cordic
// plus the shared multiplier steps; with both levels zero the vectoring pass
// is skipped. s_tready is high only while the sequencer is idle. a finished
// result sits in the output register; the next word is accepted while it waits,
// and the sequencer holds at its end until the output register is free.
// aresetn is synchronous and active low; it clears levels and loads reset gains.
// ----------------------------------------------------------------------------
module polar_differential_drive_mixer import pddm_pkg::*; #(
    parameter int DUTY_BITS    = 12,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [31:0]                           s_tdata,  // steering_cmd, throttle_cmd
    input  logic [1:0]                            s_tuser,  // mode
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // left_forward_duty, left_reverse_duty, right_forward_duty, right_reverse_duty
    output logic [((4*DUTY_BITS+7)/8)*8-1:0]      m_tdata,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [3:0]                            paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);

    localparam int M_DATA_W = ((4*DUTY_BITS+7)/8)*8;
    localparam int P_W      = 65;
    localparam int MAG_W    = 25;

    localparam logic [DUTY_BITS-1:0] FS       = {DUTY_BITS{1'b1}};
    localparam logic [MAG_W-1:0]     MAG_ONE  = 25'd16777216;
    localparam logic signed [P_W-1:0] HALF_12 = 65'sd2048;
    localparam logic signed [P_W-1:0] HALF_24 = 65'sd8388608;
    localparam logic signed [P_W-1:0] HALF_30 = 65'sd536870912;

    localparam logic [4:0] ST_IDLE     = 5'd0;
    localparam logic [4:0] ST_MUL_S    = 5'd1;
    localparam logic [4:0] ST_MUL_T    = 5'd2;
    localparam logic [4:0] ST_LVL_T    = 5'd3;
    localparam logic [4:0] ST_VEC_LOAD = 5'd4;
    localparam logic [4:0] ST_VEC_RUN  = 5'd5;
    localparam logic [4:0] ST_MAG_MUL  = 5'd6;
    localparam logic [4:0] ST_MAG      = 5'd7;
    localparam logic [4:0] ST_RMUL     = 5'd8;
    localparam logic [4:0] ST_RX       = 5'd9;
    localparam logic [4:0] ST_PHI      = 5'd10;
    localparam logic [4:0] ST_WRAP     = 5'd11;
    localparam logic [4:0] ST_FOLD     = 5'd12;
    localparam logic [4:0] ST_ROT_LOAD = 5'd13;
    localparam logic [4:0] ST_ROT_RUN  = 5'd14;
    localparam logic [4:0] ST_DMUL     = 5'd15;
    localparam logic [4:0] ST_DUTY     = 5'd16;
    localparam logic [4:0] ST_DONE     = 5'd17;

    localparam logic [1:0] WRAP_LAST = 2'd2;

    logic [4:0] state_reg, state_next;

    // configuration
    logic signed [15:0] sgain_reg, tgain_reg;
    logic signed [14:0] offset_reg;
    logic               cfg_wr;

    // item and kept levels
    logic [1:0]         mode_reg;
    logic signed [15:0] scmd_reg, tcmd_reg;
    logic signed [19:0] steer_lvl_reg, thr_lvl_reg;

    // shared multiplier
    logic signed [32:0]    mul_a;
    logic signed [31:0]    mul_b;
    logic signed [P_W-1:0] prod_reg;

    // datapath holding registers
    logic signed [ANG_W-1:0] zv_reg, phi_reg;
    logic [MAG_W-1:0]        r_reg;
    logic signed [XY_W-1:0]  x0_reg;
    logic                    neg_reg, wheel_reg, cpos_reg, cneg_reg;
    logic [1:0]              wrap_cnt_reg;
    logic [DUTY_BITS-1:0]    lf_reg, lr_reg, rf_reg, rr_reg;
    logic [M_DATA_W-1:0]     m_data_reg;
    logic                    m_valid_reg;

    // cordic
    cordic_ctl_t             cordic_ctl;
    logic signed [XY_W-1:0]  cx_in, cy_in, cx;
    logic signed [ANG_W-1:0] cz_in, cz;
    logic                    cordic_done;

    // combinational datapath
    logic signed [P_W-1:0]   rnd12, rnd24, rnd30;
    logic signed [19:0]      lvl_new;
    logic signed [XY_W-1:0]  vx, vy, vec_x0, vec_y0;
    logic signed [ANG_W-1:0] vec_z0;
    logic                    lvl_zero;
    logic signed [34:0]      mag_raw;
    logic [MAG_W-1:0]        mag_clamped;
    logic signed [ANG_W-1:0] off_ext, phi_init, phi_wrapped, phi_folded;
    logic                    neg_fold;
    logic [XY_W-1:0]         x_abs;
    logic [40:0]             duty_raw;
    logic [DUTY_BITS-1:0]    duty_sat;
    logic                    out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        case (paddr[3:2])
            REG_STEERING_GAIN: prdata = 32'(sgain_reg);
            REG_THROTTLE_GAIN: prdata = 32'(tgain_reg);
            REG_ANGLE_OFFSET:  prdata = 32'(offset_reg);
            default:           prdata = '0;
        endcase
    end

    // multiplier operand selection
    always_comb begin
        case (state_reg)
            ST_MUL_S: begin
                mul_a = 33'(scmd_reg);
                mul_b = 32'(sgain_reg);
            end
            ST_MUL_T: begin
                mul_a = 33'(tcmd_reg);
                mul_b = 32'(tgain_reg);
            end
            ST_MAG_MUL: begin
                mul_a = 33'(cx);
                mul_b = INV_K;
            end
            ST_RMUL: begin
                mul_a = $signed({8'b0, r_reg});
                mul_b = INV_K;
            end
            ST_DMUL: begin
                mul_a = $signed({1'b0, x_abs});
                mul_b = $signed({{(32-DUTY_BITS){1'b0}}, FS});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= P_W'(mul_a) * P_W'(mul_b);
    end

    always_comb begin
        rnd12   = prod_reg + HALF_12;
        rnd24   = prod_reg + HALF_24;
        rnd30   = prod_reg + HALF_30;
        lvl_new = rnd12[31:12];

        // left half plane is flipped, angle starts at +/- pi
        vx       = {{3{thr_lvl_reg[19]}}, thr_lvl_reg, 9'b0};
        vy       = {{3{steer_lvl_reg[19]}}, steer_lvl_reg, 9'b0};
        lvl_zero = (thr_lvl_reg == '0) && (steer_lvl_reg == '0);
        if (thr_lvl_reg[19]) begin
            vec_x0 = -vx;
            vec_y0 = -vy;
            vec_z0 = steer_lvl_reg[19] ? -ANG_PI : ANG_PI;
        end else begin
            vec_x0 = vx;
            vec_y0 = vy;
            vec_z0 = '0;
        end

        mag_raw = rnd30[64:30];
        if (mag_raw[34]) begin
            mag_clamped = '0;
        end else if (mag_raw > $signed({10'b0, MAG_ONE})) begin
            mag_clamped = MAG_ONE;
        end else begin
            mag_clamped = mag_raw[MAG_W-1:0];
        end

        off_ext  = {{(ANG_W-31){offset_reg[14]}}, offset_reg, 16'b0};
        phi_init = zv_reg + off_ext + (wheel_reg ? ANG_QUARTER_PI : -ANG_QUARTER_PI);

        if (phi_reg > ANG_PI) begin
            phi_wrapped = phi_reg - ANG_TWO_PI;
        end else if (phi_reg < -ANG_PI) begin
            phi_wrapped = phi_reg + ANG_TWO_PI;
        end else begin
            phi_wrapped = phi_reg;
        end

        // fold into the right half plane, sign restored on the duty
        if (phi_reg > ANG_HALF_PI) begin
            phi_folded = phi_reg - ANG_PI;
            neg_fold   = 1'b1;
        end else if (phi_reg < -ANG_HALF_PI) begin
            phi_folded = phi_reg + ANG_PI;
            neg_fold   = 1'b1;
        end else begin
            phi_folded = phi_reg;
            neg_fold   = 1'b0;
        end

        x_abs    = cx[XY_W-1] ? XY_W'(-cx) : XY_W'(cx);
        duty_raw = rnd24[64:24];
        duty_sat = (duty_raw > 41'(FS)) ? FS : duty_raw[DUTY_BITS-1:0];
    end

    // cordic control and load values
    always_comb begin
        cordic_ctl.load = (state_reg == ST_VEC_LOAD) || (state_reg == ST_ROT_LOAD);
        cordic_ctl.step = ((state_reg == ST_VEC_RUN) || (state_reg == ST_ROT_RUN)) &&
                          !cordic_done;
        cordic_ctl.vec  = (state_reg == ST_VEC_LOAD) || (state_reg == ST_VEC_RUN);
        if (state_reg == ST_VEC_LOAD) begin
            cx_in = vec_x0;
            cy_in = vec_y0;
            cz_in = vec_z0;
        end else begin
            cx_in = x0_reg;
            cy_in = '0;
            cz_in = phi_reg;
        end
    end

    pddm_cordic #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (cordic_ctl),
        .x_in    (cx_in),
        .y_in    (cy_in),
        .z_in    (cz_in),
        .x_out   (cx),
        .z_out   (cz),
        .done    (cordic_done)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (s_tvalid) state_next = ST_MUL_S;
            ST_MUL_S:    state_next = ST_MUL_T;
            ST_MUL_T:    state_next = ST_LVL_T;
            ST_LVL_T:    state_next = ST_VEC_LOAD;
            ST_VEC_LOAD: state_next = lvl_zero ? ST_MAG_MUL : ST_VEC_RUN;
            ST_VEC_RUN:  if (cordic_done) state_next = ST_MAG_MUL;
            ST_MAG_MUL:  state_next = ST_MAG;
            ST_MAG:      state_next = ST_RMUL;
            ST_RMUL:     state_next = ST_RX;
            ST_RX:       state_next = ST_PHI;
            ST_PHI:      state_next = ST_WRAP;
            ST_WRAP:     if (wrap_cnt_reg == WRAP_LAST) state_next = ST_FOLD;
            ST_FOLD:     state_next = ST_ROT_LOAD;
            ST_ROT_LOAD: state_next = ST_ROT_RUN;
            ST_ROT_RUN:  if (cordic_done) state_next = ST_DMUL;
            ST_DMUL:     state_next = ST_DUTY;
            ST_DUTY:     state_next = wheel_reg ? ST_DONE : ST_PHI;
            ST_DONE:     if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // control state, configuration and kept levels
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            sgain_reg     <= 16'sd4096;
            tgain_reg     <= 16'sd4096;
            offset_reg    <= '0;
            steer_lvl_reg <= '0;
            thr_lvl_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr) begin
                case (paddr[3:2])
                    REG_STEERING_GAIN: sgain_reg  <= pwdata[15:0];
                    REG_THROTTLE_GAIN: tgain_reg  <= pwdata[15:0];
                    REG_ANGLE_OFFSET:  offset_reg <= pwdata[14:0];
                    default: ;
                endcase
            end
            if (state_reg == ST_MUL_T &&
                (mode_reg == MODE_STEERING || mode_reg == MODE_BOTH)) begin
                steer_lvl_reg <= lvl_new;
            end
            if (state_reg == ST_LVL_T &&
                (mode_reg == MODE_THROTTLE || mode_reg == MODE_BOTH)) begin
                thr_lvl_reg <= lvl_new;
            end
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath payload
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    mode_reg <= s_tuser;
                    scmd_reg <= s_tdata[15:0];
                    tcmd_reg <= s_tdata[31:16];
                end
            end
            ST_MAG_MUL: zv_reg <= cz;
            ST_MAG:     r_reg  <= mag_clamped;
            ST_RX: begin
                x0_reg    <= rnd30[30+XY_W-1:30];
                wheel_reg <= 1'b0;
            end
            ST_PHI: begin
                phi_reg      <= phi_init;
                wrap_cnt_reg <= '0;
            end
            ST_WRAP: begin
                phi_reg      <= phi_wrapped;
                wrap_cnt_reg <= wrap_cnt_reg + 1'b1;
            end
            ST_FOLD: begin
                phi_reg <= phi_folded;
                neg_reg <= neg_fold;
            end
            ST_DMUL: begin
                cpos_reg <= (|cx) && (cx[XY_W-1] == neg_reg);
                cneg_reg <= (|cx) && (cx[XY_W-1] != neg_reg);
            end
            ST_DUTY: begin
                if (wheel_reg) begin
                    rf_reg <= cpos_reg ? duty_sat : '0;
                    rr_reg <= cneg_reg ? duty_sat : '0;
                end else begin
                    lf_reg <= cpos_reg ? duty_sat : '0;
                    lr_reg <= cneg_reg ? duty_sat : '0;
                end
                wheel_reg <= 1'b1;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_data_reg <= M_DATA_W'({rr_reg, rf_reg, lr_reg, lf_reg});
                end
            end
            default: ;
        endcase
    end

    // one word in flight at a time
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second word accepted while busy");

    // a wheel never drives both channels
    a_one_channel: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !((m_tdata[DUTY_BITS-1:0] != '0) &&
                       (m_tdata[2*DUTY_BITS-1:DUTY_BITS] != '0)) &&
                     !((m_tdata[3*DUTY_BITS-1:2*DUTY_BITS] != '0) &&
                       (m_tdata[4*DUTY_BITS-1:3*DUTY_BITS] != '0)))
        else $error("forward and reverse both active");

    a_mag_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_RMUL |-> r_reg <= MAG_ONE)
        else $error("magnitude above one");

    a_phi_wrapped: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FOLD |-> (phi_reg <= ANG_PI) && (phi_reg >= -ANG_PI))
        else $error("angle not wrapped into range");

    a_cordic_step: assert property (@(posedge aclk) disable iff (!aresetn)
        cordic_ctl.step |-> !cordic_done && !cordic_ctl.load)
        else $error("cordic stepped past its last iteration");

endmodule
